@@ src/rdtd_pkg.sv @@
// Shared types, codes and constants of the random deadline task dispatcher.
package rdtd_pkg;

	// One input word as it arrives on the request channel.
	typedef struct packed {
		logic        req_type;
		logic [15:0] task_id;
		logic [15:0] task_deadline;
		logic [11:0] process_ticks;
		logic        hard_task;
	} req_word_t;

	typedef enum logic [2:0] {
		EV_COMPLETED = 3'd0,
		EV_ASSIGNED  = 3'd1,
		EV_HARD_DROP = 3'd2,
		EV_SOFT_DROP = 3'd3,
		EV_TICK_END  = 3'd4,
		EV_OVERFLOW  = 3'd5
	} ev_kind_t;

	// One result word as it leaves on the event channel.
	typedef struct packed {
		ev_kind_t    event_kind;
		logic [15:0] event_task;
		logic [3:0]  event_processor;
		logic [15:0] event_time;
		logic [7:0]  busy_map;
		logic        last;
	} evt_word_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] deadline;
		logic [11:0] ticks;
		logic        hard;
	} task_t;

	typedef struct packed {
		logic  is_tick;
		task_t tsk;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_push_t;

	// Configuration as seen by the engine.
	typedef struct packed {
		logic [3:0]  num_processors;
		logic [7:0]  batch_period;
		logic        seed_load;
		logic [31:0] seed;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TMOD,
		ST_SV_RD,
		ST_SV_CHK,
		ST_D_RD,
		ST_D_CHK,
		ST_D_MOD,
		ST_D_ADM,
		ST_TEND
	} back_state_t;

	localparam logic REQ_TICK = 1'b1;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED     = 2'd2;

	localparam logic [3:0]  NUM_PROCS_RST    = 4'd4;
	localparam logic [7:0]  BATCH_PERIOD_RST = 8'd3;
	localparam logic [31:0] LFSR_RST         = 32'd1;
	localparam logic [31:0] LFSR_TAPS        = 32'h8020_0003;

	// Remainder unit: 32-bit dividend, 8-bit divisor, four quotient bits a cycle.
	localparam int MOD_DVD_W  = 32;
	localparam int MOD_DIV_W  = 8;
	localparam int MOD_BITS   = 4;
	localparam int MOD_CYCLES = MOD_DVD_W / MOD_BITS;
	localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

	localparam int CMDQ_DEPTH = 2;

	// Galois LFSR, right shift.
	function automatic logic [31:0] lfsr_next(input logic [31:0] v);
		logic [31:0] r;
		r = v >> 1;
		if (v[0]) begin
			r = r ^ LFSR_TAPS;
		end
		return r;
	endfunction

endpackage

@@ src/random_deadline_task_dispatcher.sv @@
// Top level of the random deadline task dispatcher.
//
// Usage. Request words enter on req (req_valid, req_stall). An arrival
// word appends a task to the pending list; a tick word services every
// processor queue in use, dispatches the pending list on batch ticks and
// advances time. Event words leave on evt (evt_valid, evt_stall); the last
// event caused by one request carries the last flag. A successful arrival
// gives no event; every tick ends with a tick end event.
// Structure. A request passes one front register and a two-entry command
// queue, so the front keeps taking words while the engine works. The
// engine takes an arrival in its idle state. A tick's work grows with the
// processors in use and the completions, and on batch ticks with the
// dropped tasks and the tasks that draw a processor; the remainder unit
// sets most of it, once for the batch test and once per random pick. The
// queue store is a single port memory; the pending list has separate read
// and write addresses. Both are read one entry a cycle.
// Reset clears time, the pending list, all processor queues and loads the
// LFSR with one; no clearing pass is needed. On a receiver stall the engine
// holds its next event and waits; the front fills its queue and raises req_stall.
// The user writes configuration only while the block is idle; it is not enforced.
module random_deadline_task_dispatcher #(
	parameter int PROCS         = 8,
	parameter int PENDING_DEPTH = 16,
	parameter int QUEUE_DEPTH   = 8,
	parameter int TIME_BITS     = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  rdtd_pkg::req_word_t                   req,
	output logic                                  evt_valid,
	input  logic                                  evt_stall,
	output rdtd_pkg::evt_word_t                   evt,
	input  logic                                  cfg_we,
	input  logic [rdtd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rdtd_pkg::CFG_W-1:0]            cfg_data
);

	// Register file: processors in use and the batch period live here; a
	// seed write goes straight to the engine's LFSR.
	logic [3:0]          num_procs_q;
	logic [7:0]          batch_period_q;
	rdtd_pkg::cfg_t      cfg;
	rdtd_pkg::cmd_push_t push;
	logic                q_ready;
	logic                cmd_valid;
	rdtd_pkg::cmd_t      cmd;
	logic                cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_procs_q    <= rdtd_pkg::NUM_PROCS_RST;
			batch_period_q <= rdtd_pkg::BATCH_PERIOD_RST;
		end else if (cfg_we) begin
			if (cfg_index == rdtd_pkg::CFG_NUM_PROCS) begin
				num_procs_q <= cfg_data[3:0];
			end
			if (cfg_index == rdtd_pkg::CFG_BATCH_PERIOD) begin
				batch_period_q <= cfg_data[7:0];
			end
		end
	end

	assign cfg.num_processors = num_procs_q;
	assign cfg.batch_period   = batch_period_q;
	assign cfg.seed_load      = cfg_we && (cfg_index == rdtd_pkg::CFG_RNG_SEED);
	assign cfg.seed           = cfg_data;

	// Front: classifies requests and normalizes the process time.
	rdtd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.q_ready   (q_ready)
	);

	// Decouples the front from the engine.
	rdtd_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.ready     (q_ready),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Engine with its own output register toward the event channel.
	rdtd_back #(
		.PROCS         (PROCS),
		.PENDING_DEPTH (PENDING_DEPTH),
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.TIME_BITS     (TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

endmodule

@@ src/rdtd_front.sv @@
// Front stage: takes request words and turns them into engine commands.
module rdtd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  rdtd_pkg::req_word_t  req,
	output rdtd_pkg::cmd_push_t  push,
	input  logic                 q_ready
);

	logic           valid_s1;
	rdtd_pkg::cmd_t cmd_s1;
	rdtd_pkg::cmd_t cmd_d;
	logic           accept;
	logic           drain;

	assign drain     = valid_s1 && q_ready;
	assign req_stall = valid_s1 && !q_ready;
	assign accept    = req_valid && !req_stall;

	// A zero process time counts as one tick.
	always_comb begin
		cmd_d.is_tick      = (req.req_type == rdtd_pkg::REQ_TICK);
		cmd_d.tsk.id       = req.task_id;
		cmd_d.tsk.deadline = req.task_deadline;
		cmd_d.tsk.ticks    = (req.process_ticks == 12'd0) ? 12'd1 : req.process_ticks;
		cmd_d.tsk.hard     = req.hard_task;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push.valid = valid_s1;
	assign push.cmd   = cmd_s1;

endmodule

@@ src/rdtd_cmdq.sv @@
// Short command queue between the front stage and the engine.
module rdtd_cmdq (
	input  logic                clk,
	input  logic                arst_n,
	input  rdtd_pkg::cmd_push_t push,
	output logic                ready,
	output logic                cmd_valid,
	output rdtd_pkg::cmd_t      cmd,
	input  logic                cmd_pop
);

	localparam int AW = $clog2(rdtd_pkg::CMDQ_DEPTH);
	localparam int CW = $clog2(rdtd_pkg::CMDQ_DEPTH + 1);

	rdtd_pkg::cmd_t        slots_q [rdtd_pkg::CMDQ_DEPTH];
	logic [AW-1:0]         wr_q;
	logic [AW-1:0]         rd_q;
	logic [CW-1:0]         cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign ready     = (cnt_q != CW'(rdtd_pkg::CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slots_q[rd_q];
	assign do_push   = push.valid && ready;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(rdtd_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(rdtd_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push.cmd;
		end
	end

endmodule

@@ src/rdtd_mod.sv @@
// Iterative remainder unit, four restoring steps per cycle.
module rdtd_mod (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [rdtd_pkg::MOD_DVD_W-1:0]     dividend,
	input  logic [rdtd_pkg::MOD_DIV_W-1:0]     divisor,
	output logic                               busy,
	output logic [rdtd_pkg::MOD_DIV_W-1:0]     rem
);

	localparam int DW = rdtd_pkg::MOD_DIV_W;

	logic [rdtd_pkg::MOD_DVD_W-1:0] sh_q;
	logic [DW-1:0]                  div_q;
	logic [DW-1:0]                  r_q;
	logic [DW-1:0]                  r_d;
	logic [rdtd_pkg::MOD_CNT_W-1:0] cnt_q;
	logic                           busy_q;

	always_comb begin
		logic [DW:0] t;
		r_d = r_q;
		for (int k = 0; k < rdtd_pkg::MOD_BITS; k++) begin
			t = {r_d, sh_q[rdtd_pkg::MOD_DVD_W-1-k]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			r_d = t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == rdtd_pkg::MOD_CNT_W'(rdtd_pkg::MOD_CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			div_q <= divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << rdtd_pkg::MOD_BITS;
			r_q  <= r_d;
		end
	end

	assign busy = busy_q;
	assign rem  = r_q;

endmodule

@@ src/rdtd_back.sv @@
// Engine: pending list, processor queues, tick servicing and dispatch.
module rdtd_back #(
	parameter int PROCS         = 8,
	parameter int PENDING_DEPTH = 16,
	parameter int QUEUE_DEPTH   = 8,
	parameter int TIME_BITS     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rdtd_pkg::cfg_t       cfg,
	input  logic                 cmd_valid,
	input  rdtd_pkg::cmd_t       cmd,
	output logic                 cmd_pop,
	output logic                 evt_valid,
	input  logic                 evt_stall,
	output rdtd_pkg::evt_word_t  evt
);

	localparam int PW   = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int PMW  = $clog2(PROCS + 1);
	localparam int PAW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCW  = $clog2(PENDING_DEPTH + 1);
	localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
	localparam int QN   = PROCS * QUEUE_DEPTH;
	localparam int QMW  = (QN > 1) ? $clog2(QN) : 1;
	localparam int XW   = ((TIME_BITS > 16) ? TIME_BITS : 16) + 2;

	typedef struct packed {
		logic [15:0] id;
		logic [11:0] ticks;
	} qent_t;

	rdtd_pkg::back_state_t state_q, state_d;

	logic [TIME_BITS-1:0] t_q;
	logic [PCW-1:0]       pc_q;
	logic [PCW-1:0]       i_q;
	logic [PCW-1:0]       keep_q;
	logic [PW-1:0]        p_q;
	logic                 zero_rem_q;
	logic [31:0]          lfsr_q;
	logic [31:0]          lfsr_nx;

	logic [QAW-1:0]       head_q    [PROCS];
	logic [QCW-1:0]       cnt_q     [PROCS];
	logic                 started_q [PROCS];
	logic [TIME_BITS-1:0] end_q     [PROCS];
	logic [TIME_BITS-1:0] busy_q    [PROCS];

	rdtd_pkg::task_t      pmem [PENDING_DEPTH];
	rdtd_pkg::task_t      prd_q;
	qent_t                qmem [QN];
	qent_t                qrd_q;

	rdtd_pkg::evt_word_t  out_q;
	logic                 out_valid_q;
	logic                 can_emit;

	// Remainder unit hookup.
	logic                 mod_start;
	logic [31:0]          mod_dividend;
	logic [7:0]           mod_divisor;
	logic                 mod_busy;
	logic [7:0]           mod_rem;

	// Engine actions.
	logic                 emit;
	rdtd_pkg::evt_word_t  emit_word;
	rdtd_pkg::ev_kind_t   emit_kind;
	logic [15:0]          emit_task;
	logic                 emit_has_proc;
	logic                 emit_last;
	logic                 pend_we;
	logic [PAW-1:0]       pend_waddr;
	logic                 arr_push;
	logic                 tmod_done;
	logic                 sv_start_a;
	logic                 sv_pop_a;
	logic                 p_inc;
	logic                 disp_init;
	logic                 lfsr_adv;
	logic                 adm_a;
	logic                 keep_a;
	logic                 item_done;
	logic                 t_inc;

	// Decoded conditions.
	logic [4:0]           np5;
	logic [PMW-1:0]       m_w;
	logic [7:0]           bp_n;
	logic                 dispatching;
	logic [PW-1:0]        sel_p;
	logic                 last_p;
	logic                 last_i;
	logic                 go_disp;
	logic                 sv_empty;
	logic                 sv_start;
	logic                 sv_done;
	logic                 sv_next;
	logic [XW-1:0]        t_x;
	logic [XW-1:0]        t1_x;
	logic [XW-1:0]        tk_x;
	logic [XW-1:0]        dl_x;
	logic [XW-1:0]        need_x;
	logic [XW-1:0]        busy_x;
	logic [XW-1:0]        base_x;
	logic                 drop;
	logic                 fits;
	logic                 q_full;
	logic                 admit;
	logic [TIME_BITS-1:0] busy_new;
	logic [TIME_BITS-1:0] end_new;
	logic [QCW:0]         slot_sum;
	logic [QAW-1:0]       slot_tail;
	logic [QAW-1:0]       slot;
	logic [QMW-1:0]       qaddr;
	logic [7:0]           busy_map;

	assign np5  = {1'b0, cfg.num_processors};
	assign m_w  = (np5 == 5'd0) ? PMW'(1) :
	              (np5 > 5'(PROCS)) ? PMW'(PROCS) : PMW'(np5);
	assign bp_n = (cfg.batch_period == 8'd0) ? 8'd1 : cfg.batch_period;

	assign dispatching = (state_q == rdtd_pkg::ST_D_RD) || (state_q == rdtd_pkg::ST_D_CHK) ||
	                     (state_q == rdtd_pkg::ST_D_MOD) || (state_q == rdtd_pkg::ST_D_ADM);
	assign sel_p   = dispatching ? mod_rem[PW-1:0] : p_q;
	assign last_p  = ((PMW'(p_q) + PMW'(1)) == m_w);
	assign last_i  = ((i_q + 1'b1) == pc_q);
	assign go_disp = zero_rem_q && (pc_q != '0);
	assign can_emit = !out_valid_q || !evt_stall;

	// Servicing the front of one processor queue.
	assign sv_empty = (cnt_q[sel_p] == '0);
	assign sv_start = !sv_empty && !started_q[sel_p];
	assign sv_done  = !sv_empty && started_q[sel_p] && (end_q[sel_p] == t_q);
	assign sv_next  = !sv_done;
	assign end_new  = TIME_BITS'(t_x + XW'(qrd_q.ticks));

	// Deadline tests are taken without wrap.
	assign t_x    = XW'(t_q);
	assign t1_x   = t_x + XW'(1);
	assign tk_x   = XW'(prd_q.ticks);
	assign dl_x   = XW'(prd_q.deadline);
	assign need_x = t1_x + tk_x;
	assign drop   = (need_x > dl_x);
	assign busy_x = XW'(busy_q[sel_p]);
	assign base_x = (busy_x > t1_x) ? busy_x : t1_x;
	assign fits   = ((base_x + tk_x) <= dl_x);
	assign q_full = !(cnt_q[sel_p] < QCW'(QUEUE_DEPTH));
	assign admit  = fits && !q_full;
	assign busy_new = ((busy_q[sel_p] == '0) || (busy_q[sel_p] <= t_q)) ?
	                  TIME_BITS'(need_x) : TIME_BITS'(busy_x + tk_x);

	// Tail slot of the picked queue, head plus count around the ring.
	assign slot_sum  = (QCW+1)'(head_q[sel_p]) + (QCW+1)'(cnt_q[sel_p]);
	assign slot_tail = (slot_sum >= (QCW+1)'(QUEUE_DEPTH)) ?
	                   QAW'(slot_sum - (QCW+1)'(QUEUE_DEPTH)) : QAW'(slot_sum);
	assign slot  = dispatching ? slot_tail : head_q[sel_p];
	assign qaddr = QMW'(sel_p) * QMW'(QUEUE_DEPTH) + QMW'(slot);

	assign lfsr_nx = rdtd_pkg::lfsr_next(lfsr_q);

	for (genvar g = 0; g < 8; g++) begin : g_busy
		if (g < PROCS) begin : g_on
			assign busy_map[g] = (cnt_q[g] != '0) && started_q[g];
		end else begin : g_off
			assign busy_map[g] = 1'b0;
		end
	end

	rdtd_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rdtd_pkg::ST_IDLE: begin
				if (cmd_valid && cmd.is_tick) begin
					state_d = rdtd_pkg::ST_TMOD;
				end
			end
			rdtd_pkg::ST_TMOD: begin
				if (!mod_busy) begin
					state_d = rdtd_pkg::ST_SV_RD;
				end
			end
			rdtd_pkg::ST_SV_RD: begin
				state_d = rdtd_pkg::ST_SV_CHK;
			end
			rdtd_pkg::ST_SV_CHK: begin
				if (sv_next) begin
					if (!last_p) begin
						state_d = rdtd_pkg::ST_SV_RD;
					end else if (go_disp) begin
						state_d = rdtd_pkg::ST_D_RD;
					end else begin
						state_d = rdtd_pkg::ST_TEND;
					end
				end else if (can_emit) begin
					state_d = rdtd_pkg::ST_SV_RD;
				end
			end
			rdtd_pkg::ST_D_RD: begin
				state_d = rdtd_pkg::ST_D_CHK;
			end
			rdtd_pkg::ST_D_CHK: begin
				if (!drop) begin
					state_d = rdtd_pkg::ST_D_MOD;
				end else if (can_emit) begin
					state_d = last_i ? rdtd_pkg::ST_TEND : rdtd_pkg::ST_D_RD;
				end
			end
			rdtd_pkg::ST_D_MOD: begin
				if (!mod_busy) begin
					state_d = rdtd_pkg::ST_D_ADM;
				end
			end
			rdtd_pkg::ST_D_ADM: begin
				if (!admit || can_emit) begin
					state_d = last_i ? rdtd_pkg::ST_TEND : rdtd_pkg::ST_D_RD;
				end
			end
			rdtd_pkg::ST_TEND: begin
				if (can_emit) begin
					state_d = rdtd_pkg::ST_IDLE;
				end
			end
			default: state_d = rdtd_pkg::ST_IDLE;
		endcase
	end

	// Actions of each state.
	always_comb begin
		cmd_pop       = 1'b0;
		emit          = 1'b0;
		emit_kind     = rdtd_pkg::EV_TICK_END;
		emit_task     = 16'd0;
		emit_has_proc = 1'b0;
		emit_last     = 1'b0;
		pend_we       = 1'b0;
		pend_waddr    = pc_q[PAW-1:0];
		arr_push      = 1'b0;
		tmod_done     = 1'b0;
		sv_start_a    = 1'b0;
		sv_pop_a      = 1'b0;
		p_inc         = 1'b0;
		disp_init     = 1'b0;
		lfsr_adv      = 1'b0;
		adm_a         = 1'b0;
		keep_a        = 1'b0;
		item_done     = 1'b0;
		t_inc         = 1'b0;
		mod_start     = 1'b0;
		mod_dividend  = 32'(t_q);
		mod_divisor   = bp_n;
		unique case (state_q)
			rdtd_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.is_tick) begin
						cmd_pop   = 1'b1;
						mod_start = 1'b1;
					end else if (pc_q < PCW'(PENDING_DEPTH)) begin
						cmd_pop  = 1'b1;
						pend_we  = 1'b1;
						arr_push = 1'b1;
					end else if (can_emit) begin
						cmd_pop   = 1'b1;
						emit      = 1'b1;
						emit_kind = rdtd_pkg::EV_OVERFLOW;
						emit_task = cmd.tsk.id;
						emit_last = 1'b1;
					end
				end
			end
			rdtd_pkg::ST_TMOD: begin
				tmod_done = !mod_busy;
			end
			rdtd_pkg::ST_SV_CHK: begin
				if (sv_next) begin
					sv_start_a = sv_start;
					p_inc      = !last_p;
					disp_init  = last_p && go_disp;
				end else if (can_emit) begin
					emit          = 1'b1;
					emit_kind     = rdtd_pkg::EV_COMPLETED;
					emit_task     = qrd_q.id;
					emit_has_proc = 1'b1;
					sv_pop_a      = 1'b1;
				end
			end
			rdtd_pkg::ST_D_CHK: begin
				if (drop) begin
					if (can_emit) begin
						emit      = 1'b1;
						emit_kind = prd_q.hard ? rdtd_pkg::EV_HARD_DROP :
						                         rdtd_pkg::EV_SOFT_DROP;
						emit_task = prd_q.id;
						item_done = 1'b1;
					end
				end else begin
					lfsr_adv     = 1'b1;
					mod_start    = 1'b1;
					mod_dividend = lfsr_nx;
					mod_divisor  = 8'(m_w);
				end
			end
			rdtd_pkg::ST_D_ADM: begin
				if (admit) begin
					if (can_emit) begin
						emit          = 1'b1;
						emit_kind     = rdtd_pkg::EV_ASSIGNED;
						emit_task     = prd_q.id;
						emit_has_proc = 1'b1;
						adm_a         = 1'b1;
						item_done     = 1'b1;
					end
				end else begin
					keep_a     = 1'b1;
					pend_we    = 1'b1;
					pend_waddr = keep_q[PAW-1:0];
					item_done  = 1'b1;
				end
			end
			rdtd_pkg::ST_TEND: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_kind = rdtd_pkg::EV_TICK_END;
					emit_last = 1'b1;
					t_inc     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		emit_word.event_kind      = emit_kind;
		emit_word.event_task      = emit_task;
		emit_word.event_processor = emit_has_proc ? 4'({1'b0, sel_p} + 1'b1) : 4'd0;
		emit_word.event_time      = 16'(t_q);
		emit_word.busy_map        = busy_map;
		emit_word.last            = emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdtd_pkg::ST_IDLE;
			t_q         <= '0;
			pc_q        <= '0;
			i_q         <= '0;
			keep_q      <= '0;
			p_q         <= '0;
			zero_rem_q  <= 1'b0;
			lfsr_q      <= rdtd_pkg::LFSR_RST;
			out_valid_q <= 1'b0;
			for (int k = 0; k < PROCS; k++) begin
				head_q[k]    <= '0;
				cnt_q[k]     <= '0;
				started_q[k] <= 1'b0;
				end_q[k]     <= '0;
				busy_q[k]    <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.seed_load) begin
				lfsr_q <= (cfg.seed == 32'd0) ? 32'd1 : cfg.seed;
			end else if (lfsr_adv) begin
				lfsr_q <= lfsr_nx;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				out_valid_q <= 1'b0;
			end
			if (t_inc) begin
				t_q <= t_q + 1'b1;
			end
			if (tmod_done) begin
				zero_rem_q <= (mod_rem == 8'd0);
				p_q        <= '0;
			end
			if (p_inc) begin
				p_q <= p_q + 1'b1;
			end
			if (sv_start_a) begin
				started_q[sel_p] <= 1'b1;
				end_q[sel_p]     <= end_new;
			end
			if (sv_pop_a) begin
				head_q[sel_p]    <= (head_q[sel_p] == QAW'(QUEUE_DEPTH - 1)) ? '0 :
				                    head_q[sel_p] + 1'b1;
				cnt_q[sel_p]     <= cnt_q[sel_p] - 1'b1;
				started_q[sel_p] <= 1'b0;
			end
			if (adm_a) begin
				cnt_q[sel_p]  <= cnt_q[sel_p] + 1'b1;
				busy_q[sel_p] <= busy_new;
			end
			if (disp_init) begin
				i_q    <= '0;
				keep_q <= '0;
			end
			if (keep_a) begin
				keep_q <= keep_q + 1'b1;
			end
			if (arr_push) begin
				pc_q <= pc_q + 1'b1;
			end else if (item_done && last_i) begin
				// Refused tasks were packed to the front; they are the new list.
				pc_q <= keep_q + PCW'(keep_a);
			end
			if (item_done) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_word;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pmem[pend_waddr] <= arr_push ? cmd.tsk : prd_q;
		end
		prd_q <= pmem[i_q[PAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (adm_a) begin
			qmem[qaddr] <= '{id: prd_q.id, ticks: prd_q.ticks};
		end
		qrd_q <= qmem[qaddr];
	end

	assign evt_valid = out_valid_q;
	assign evt       = out_q;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PCW'(PENDING_DEPTH))
		else $error("pending count beyond list depth");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rdtd_pkg::ST_IDLE && emit) |-> (pc_q == PCW'(PENDING_DEPTH)))
		else $error("overflow reported while the pending list has room");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last == (out_q.event_kind == rdtd_pkg::EV_TICK_END ||
		                                out_q.event_kind == rdtd_pkg::EV_OVERFLOW)))
		else $error("last flag on the wrong event kind");

	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		t_inc |=> (t_q == TIME_BITS'($past(t_q) + 1'b1)))
		else $error("time did not advance by one at tick end");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the random deadline task dispatcher.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPROC       = 8;
	localparam int PEND_DEPTH  = 16;
	localparam int QDEPTH      = 8;
	localparam int IDLE_LIMIT  = 5000;
	localparam int DRAIN_WAIT  = 60;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	rdtd_pkg::req_word_t           req;
	logic                          evt_valid;
	logic                          evt_stall;
	rdtd_pkg::evt_word_t           evt;
	logic                          cfg_we;
	logic [rdtd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rdtd_pkg::CFG_W-1:0]     cfg_data;

	random_deadline_task_dispatcher dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.evt_valid(evt_valid), .evt_stall(evt_stall), .evt(evt),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Free running clock with a 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Events that the dispatcher owes us, oldest first.
	rdtd_pkg::evt_word_t owed_events[$];
	int        mismatches;
	int        words_sent;
	int        events_seen;
	int        gap_max;
	int        stall_max;
	int        hold_left;
	int        stall_left;
	int        idle_cycles;

	// Our own copy of the scheduler state and its configuration.
	logic [3:0]       sched_nproc;
	logic [7:0]       sched_period;
	logic [15:0]      sched_time;
	rdtd_pkg::task_t  sched_pend[PEND_DEPTH];
	int               sched_pcnt;
	rdtd_pkg::task_t  sched_queue[NPROC][QDEPTH];
	int               sched_head[NPROC];
	int               sched_qcnt[NPROC];
	bit               sched_started[NPROC];
	logic [15:0]      sched_end[NPROC];
	logic [15:0]      sched_busy[NPROC];
	logic [31:0]      sched_lfsr;

	// Running processors: those whose front task has been started.
	function automatic logic [7:0] running_map();
		logic [7:0] m;
		m = '0;
		for (int p = 0; p < NPROC; p++) begin
			if (sched_qcnt[p] != 0 && sched_started[p]) begin
				m[p] = 1'b1;
			end
		end
		return m;
	endfunction

	task automatic owe_event(rdtd_pkg::ev_kind_t kind, logic [15:0] id, logic [3:0] proc_no,
			logic [15:0] at);
		rdtd_pkg::evt_word_t e;
		e.event_kind      = kind;
		e.event_task      = id;
		e.event_processor = proc_no;
		e.event_time      = at;
		e.busy_map        = running_map();
		e.last            = 1'b0;
		owed_events.insert(owed_events.size(), e);
	endtask

	// Galois step of the processor picker, right shift.
	function automatic logic [31:0] picker_advance();
		logic [31:0] v;
		v = sched_lfsr >> 1;
		if (sched_lfsr[0]) begin
			v = v ^ rdtd_pkg::LFSR_TAPS;
		end
		sched_lfsr = v;
		return v;
	endfunction

	task automatic reset_schedule();
		sched_nproc  = rdtd_pkg::NUM_PROCS_RST;
		sched_period = rdtd_pkg::BATCH_PERIOD_RST;
		sched_time   = '0;
		sched_pcnt   = 0;
		sched_lfsr   = rdtd_pkg::LFSR_RST;
		for (int p = 0; p < NPROC; p++) begin
			sched_head[p]    = 0;
			sched_qcnt[p]    = 0;
			sched_started[p] = 1'b0;
			sched_end[p]     = '0;
			sched_busy[p]    = '0;
		end
	endtask

	// Start and retire front tasks on every processor in use.
	task automatic retire_and_start(logic [15:0] t, int m);
		rdtd_pkg::task_t f;
		for (int p = 0; p < m; p++) begin
			while (sched_qcnt[p] != 0) begin
				f = sched_queue[p][sched_head[p]];
				if (!sched_started[p]) begin
					sched_started[p] = 1'b1;
					sched_end[p]     = t + 16'(f.ticks);
					break;
				end
				if (sched_end[p] != t) begin
					break;
				end
				owe_event(rdtd_pkg::EV_COMPLETED, f.id, 4'(p + 1), t);
				sched_head[p]    = (sched_head[p] + 1) % QDEPTH;
				sched_qcnt[p]    = sched_qcnt[p] - 1;
				sched_started[p] = 1'b0;
			end
		end
	endtask

	// Walk the pending list: drop late tasks, try to place the others.
	task automatic place_pending(logic [15:0] t, int m);
		int    keep;
		int    p;
		int    slot;
		longint base;
		rdtd_pkg::task_t tk;
		keep = 0;
		for (int i = 0; i < sched_pcnt; i++) begin
			tk = sched_pend[i];
			if (longint'(t) + 1 + tk.ticks > longint'(tk.deadline)) begin
				owe_event(tk.hard ? rdtd_pkg::EV_HARD_DROP : rdtd_pkg::EV_SOFT_DROP,
					tk.id, 4'd0, t);
				continue;
			end
			p = int'(picker_advance() % 32'(m));
			base = (longint'(sched_busy[p]) > longint'(t) + 1) ?
				longint'(sched_busy[p]) : longint'(t) + 1;
			if (base + tk.ticks <= longint'(tk.deadline) && sched_qcnt[p] < QDEPTH) begin
				slot = (sched_head[p] + sched_qcnt[p]) % QDEPTH;
				sched_queue[p][slot] = tk;
				sched_qcnt[p] = sched_qcnt[p] + 1;
				if (sched_busy[p] == 0 || sched_busy[p] <= t) begin
					sched_busy[p] = t + 16'd1 + 16'(tk.ticks);
				end else begin
					sched_busy[p] = sched_busy[p] + 16'(tk.ticks);
				end
				owe_event(rdtd_pkg::EV_ASSIGNED, tk.id, 4'(p + 1), t);
			end else begin
				sched_pend[keep] = tk;
				keep++;
			end
		end
		sched_pcnt = keep;
	endtask

	// Work out every event one accepted request word causes.
	task automatic predict_events(rdtd_pkg::req_word_t w);
		int              n_prior;
		int              m;
		int              period;
		rdtd_pkg::task_t tk;
		n_prior = owed_events.size();
		if (w.req_type != rdtd_pkg::REQ_TICK) begin
			tk.id       = w.task_id;
			tk.deadline = w.task_deadline;
			tk.ticks    = (w.process_ticks == 0) ? 12'd1 : w.process_ticks;
			tk.hard     = w.hard_task;
			if (sched_pcnt < PEND_DEPTH) begin
				sched_pend[sched_pcnt] = tk;
				sched_pcnt++;
			end else begin
				owe_event(rdtd_pkg::EV_OVERFLOW, tk.id, 4'd0, sched_time);
			end
		end else begin
			m = (sched_nproc == 0) ? 1 : (sched_nproc > NPROC) ? NPROC : int'(sched_nproc);
			period = (sched_period == 0) ? 1 : int'(sched_period);
			retire_and_start(sched_time, m);
			if (int'(sched_time) % period == 0 && sched_pcnt != 0) begin
				place_pending(sched_time, m);
			end
			owe_event(rdtd_pkg::EV_TICK_END, 16'd0, 4'd0, sched_time);
			sched_time = sched_time + 16'd1;
		end
		if (owed_events.size() > n_prior) begin
			owed_events[owed_events.size() - 1].last = 1'b1;
		end
	endtask

	// Offer one word after a random gap, hold it until it is taken, then
	// predict what it causes. Valid stays high when the next word follows
	// without a gap.
	task automatic send_word(rdtd_pkg::req_word_t w);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		words_sent++;
		predict_events(w);
	endtask

	task automatic send_arrival(logic [15:0] id, logic [15:0] deadline,
			logic [11:0] ticks, logic hard);
		rdtd_pkg::req_word_t w;
		w.req_type      = ~rdtd_pkg::REQ_TICK;
		w.task_id       = id;
		w.task_deadline = deadline;
		w.process_ticks = ticks;
		w.hard_task     = hard;
		send_word(w);
	endtask

	// On a tick only the type matters, so the rest is filled with noise.
	task automatic send_tick();
		rdtd_pkg::req_word_t w;
		w.req_type      = rdtd_pkg::REQ_TICK;
		w.task_id       = 16'($urandom);
		w.task_deadline = 16'($urandom);
		w.process_ticks = 12'($urandom);
		w.hard_task     = 1'($urandom);
		send_word(w);
	endtask

	// Wait until every owed event has come and the engine has settled.
	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (owed_events.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [rdtd_pkg::CFG_IDX_W-1:0] idx,
			logic [rdtd_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			rdtd_pkg::CFG_NUM_PROCS: begin
				sched_nproc = value[3:0];
			end
			rdtd_pkg::CFG_BATCH_PERIOD: begin
				sched_period = value[7:0];
			end
			rdtd_pkg::CFG_RNG_SEED: begin
				sched_lfsr = (value == 0) ? 32'd1 : value;
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic configure(logic [3:0] nproc, logic [7:0] period, logic [31:0] seed);
		wait_quiet();
		write_reg(rdtd_pkg::CFG_NUM_PROCS, rdtd_pkg::CFG_W'(nproc));
		write_reg(rdtd_pkg::CFG_BATCH_PERIOD, rdtd_pkg::CFG_W'(period));
		write_reg(rdtd_pkg::CFG_RNG_SEED, seed);
	endtask

	// Receiver: check each accepted event word against the oldest owed one,
	// then stall for a drawn number of cycles, or for a long hold-off when
	// one is requested.
	always @(posedge clk) begin
		rdtd_pkg::evt_word_t want;
		if (arst_n && evt_valid && !evt_stall) begin
			events_seen++;
			if (owed_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected event word %h at %0t", evt, $realtime);
				end
			end else begin
				want = owed_events.pop_front();
				if (evt.event_kind !== want.event_kind || evt.event_task !== want.event_task
						|| evt.event_processor !== want.event_processor
						|| evt.event_time !== want.event_time
						|| evt.busy_map !== want.busy_map || evt.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("event mismatch at %0t: expected kind %0d task %h proc %0d time %0d busy %b last %b",
							$realtime, want.event_kind, want.event_task,
							want.event_processor, want.event_time, want.busy_map, want.last);
						$display("    actual kind %0d task %h proc %0d time %0d busy %b last %b",
							evt.event_kind, evt.event_task, evt.event_processor,
							evt.event_time, evt.busy_map, evt.last);
					end
				end
			end
			stall_left = $urandom_range(0, stall_max);
		end
		if (hold_left > 0) begin
			hold_left--;
			evt_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			evt_stall <= 1'b1;
		end else begin
			evt_stall <= 1'b0;
		end
	end

	// Watchdog: too many cycles without any word moving on either side.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (evt_valid && !evt_stall) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Sixteen arrivals, four with extreme field values, fill the pending list;
	// the next one overflows. Ticks then drop the late tasks and place the rest.
	task automatic test_fill_and_overflow();
		send_arrival(16'h0000, 16'h0000, 12'h000, 1'b1);
		send_arrival(16'hffff, 16'h0000, 12'h001, 1'b0);
		send_arrival(16'h1234, 16'hffff, 12'hfff, 1'b1);
		send_arrival(16'h5a5a, 16'hffff, 12'h000, 1'b0);
		for (int i = 4; i < PEND_DEPTH; i++) begin
			send_arrival(16'(i * 16'h0911), 16'(i * 3), 12'(i % 4), 1'(i));
		end
		send_arrival(16'hbeef, 16'h0040, 12'h002, 1'b1);
		repeat (6) send_tick();
	endtask

	// A single processor with dispatch on every tick: the ninth task finds
	// the processor queue full and stays pending until a slot frees up.
	task automatic test_queue_full();
		configure(4'd1, 8'd1, 32'd7);
		for (int i = 0; i < 9; i++) begin
			send_arrival(16'(16'h0100 + i), 16'hffff, 12'd1, 1'b0);
		end
		repeat (14) send_tick();
	endtask

	// Random arrivals and ticks; deadlines mostly near the current time so
	// that assignment, dropping and refusal all show up.
	task automatic test_random_mix(int count);
		logic [11:0] ticks;
		logic [15:0] deadline;
		int          pick;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 45) begin
				send_tick();
			end else begin
				pick = $urandom_range(0, 9);
				ticks = (pick == 0) ? 12'($urandom) : (pick == 1) ? 12'd0 :
					12'($urandom_range(1, 6));
				deadline = (pick >= 8) ? 16'($urandom) :
					sched_time + 16'(ticks) + 16'($urandom_range(0, 40));
				send_arrival(16'($urandom), deadline, ticks, 1'($urandom));
			end
		end
	endtask

	// The receiver holds off for a long stretch while words keep coming, so
	// the engine backs up and the request side has to stall.
	task automatic test_backpressure();
		int keep_gap;
		wait_quiet();
		keep_gap  = gap_max;
		gap_max   = 0;
		hold_left = 400;
		test_random_mix(40);
		gap_max   = keep_gap;
	endtask

	// A single processor with back-to-back words: one task with room to
	// spare and one whose deadline is too tight to be met.
	task automatic test_single_processor();
		configure(4'd1, 8'd5, 32'hffff_ffff);
		gap_max   = 0;
		stall_max = 0;
		send_arrival(16'h7777, sched_time + 16'd20, 12'd3, 1'b1);
		send_arrival(16'h8888, sched_time + 16'd2, 12'd1, 1'b0);
		repeat (40) send_tick();
	endtask

	initial begin
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req         <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		evt_stall   <= 1'b0;
		mismatches  = 0;
		words_sent  = 0;
		events_seen = 0;
		hold_left   = 0;
		stall_left  = 0;
		idle_cycles = 0;
		gap_max     = 18;
		stall_max   = 18;
		reset_schedule();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_overflow();
		test_queue_full();

		// Random phases over several register settings, extremes included:
		// a count of zero or above the maximum, a zero period, a zero seed.
		configure(4'd8, 8'd255, 32'hffff_ffff);
		test_random_mix(40);
		configure(4'd0, 8'd0, 32'd0);
		test_random_mix(40);
		configure(4'd15, 8'd2, $urandom);
		gap_max   = 0;
		stall_max = 0;
		test_random_mix(40);
		gap_max   = 18;
		stall_max = 18;
		configure(4'd5, 8'd1, $urandom);
		test_random_mix(50);
		test_backpressure();
		configure(4'd3, 8'd4, $urandom);
		test_random_mix(40);
		configure(4'd8, 8'd1, 32'd1);
		test_random_mix(40);

		test_single_processor();

		wait_quiet();
		$display("covered %0d request words and %0d event words: overflow, queue full,",
			words_sent, events_seen);
		$display("register extremes, a long receiver hold-off and a single processor");
		if (mismatches == 0 && owed_events.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d mismatches, %0d events never arrived", mismatches,
				owed_events.size());
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
